// ===== design/span_rate_limiter_core_macros.svh =====
// Assertion helpers for the rate limiter RTL.
`ifndef SPAN_RATE_LIMITER_CORE_MACROS_SVH
`define SPAN_RATE_LIMITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent holds in a cycle, consequent holds in the same cycle.
`define SRL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srl assertion failed");
// Antecedent holds in a cycle, consequent holds in the next cycle.
`define SRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srl assertion failed");
`else
`define SRL_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SRL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/srl_pkg.sv =====
package srl_pkg;

   localparam int TS_W       = 48;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPANS_PER_SECOND   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPANS_PER_WINDOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_THRESHOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_INTERVAL_MS = 3'd4;

   // Configuration reset values
   localparam logic [CSR_DATA_W-1:0] SPANS_PER_SECOND_RST   = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] WINDOW_MS_RST          = 16'd100;
   localparam logic [CSR_DATA_W-1:0] SPANS_PER_WINDOW_RST   = 16'd100;
   localparam logic [CSR_DATA_W-1:0] REPORT_THRESHOLD_RST   = 16'd100;
   localparam logic [CSR_DATA_W-1:0] REPORT_INTERVAL_MS_RST = 16'd1000;

   // Milliseconds per second and the residue of 2^(10k) modulo 1000
   localparam int MS_PER_SECOND = 1000;
   localparam int WSUM_W        = 21;
   localparam int REM_W         = 10;
   localparam logic [REM_W-1:0] CHUNK_W1 = 10'd24;
   localparam logic [REM_W-1:0] CHUNK_W2 = 10'd576;
   localparam logic [REM_W-1:0] CHUNK_W3 = 10'd824;
   localparam logic [REM_W-1:0] CHUNK_W4 = 10'd776;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic [TS_W-1:0] now;
      logic            has_id;
      logic            taken;
   } srl_evt_type;

endpackage

// ===== design/srl_if.sv =====
interface srl_req_if;
   logic                      valid;
   logic                      ready;
   logic [srl_pkg::TS_W-1:0]  timestamp_ms;
   logic                      has_trace_id;
   logic                      report_taken;

   modport source (output valid, timestamp_ms, has_trace_id, report_taken, input ready);
   modport sink (input valid, timestamp_ms, has_trace_id, report_taken, output ready);
endinterface

interface srl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      collected;
   logic                      report_due;
   logic [srl_pkg::CNT_W-1:0] pending_count;

   modport source (output valid, collected, report_due, pending_count, input ready);
   modport sink (input valid, collected, report_due, pending_count, output ready);
endinterface

interface srl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [srl_pkg::CSR_IDX_W-1:0]  index;
   logic [srl_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/span_rate_limiter_core.sv =====
// A transaction passes through stages s1, s2 and s3 into the result register.
// Throughput: one per cycle unless rsp_bus.ready stalls; limiter state updates in s3.
// The two stages ahead of it form the event time modulo 1000 for the second boundary.
// Reset (synchronous, active high) clears the limiter state and pipeline valids
// and loads the configuration registers with their default values.
`include "span_rate_limiter_core_macros.svh"

module span_rate_limiter_core (
   input  logic      clock,
   input  logic      reset,
   srl_req_if.sink   req_bus,
   srl_rsp_if.source rsp_bus,
   srl_csr_if.sink   csr_bus
);

   localparam int TW = srl_pkg::TS_W;
   localparam int CW = srl_pkg::CNT_W;
   localparam int RW = srl_pkg::REM_W;
   localparam int SW = srl_pkg::WSUM_W;

   // Configuration registers
   logic [CW-1:0] sps_ff, win_ms_ff, spw_ff, thresh_ff, interval_ff;

   // Pipeline
   logic                 s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   srl_pkg::srl_evt_type s1_evt_ff, s2_evt_ff, s3_evt_ff;
   logic [SW-1:0]        s2_wsum_ff;
   logic [RW-1:0]        s3_rem_ff;
   logic                 ready_s1, ready_s2, ready_s3, ready_rsp;
   logic                 s3_fire;

   // Limiter state
   logic [TW-1:0] win_start_ff, win_start_in;
   logic [TW:0]   sec_next_ff, sec_next_in;
   logic [CW-1:0] win_cnt_ff, win_cnt_in;
   logic [CW-1:0] sec_cnt_ff, sec_cnt_in;
   logic [TW-1:0] last_rep_ff, last_rep_in;
   logic [CW-1:0] pend_ff, pend_in;

   // Result register
   logic          rsp_collected_ff, rsp_collected_in;
   logic          rsp_due_ff, rsp_due_in;

   // Stage arithmetic
   logic [SW-1:0]  wsum_in;
   logic [15:0]    red1;
   logic [10:0]    red2;
   logic [RW-1:0]  rem_in;
   logic [TW:0]    now_x, win_end, boundary, rep_limit;
   logic [TW-1:0]  rep_base;
   logic [CW-1:0]  sec_base, pend_base;
   logic           in_win;

   // Advance each stage when the next one is empty or moving
   assign ready_rsp = !rsp_v_ff || rsp_bus.ready;
   assign ready_s3  = !s3_v_ff || ready_rsp;
   assign ready_s2  = !s2_v_ff || ready_s3;
   assign ready_s1  = !s1_v_ff || ready_s2;
   assign s3_fire   = s3_v_ff && ready_rsp;

   assign req_bus.ready = ready_s1;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_v_ff;
   assign rsp_bus.collected     = rsp_collected_ff;
   assign rsp_bus.report_due    = rsp_due_ff;
   assign rsp_bus.pending_count = pend_ff;

   // Weighted sum of 10-bit chunks, congruent to the time modulo 1000
   assign wsum_in = SW'(s1_evt_ff.now[9:0])
                  + SW'(s1_evt_ff.now[19:10]) * SW'(srl_pkg::CHUNK_W1)
                  + SW'(s1_evt_ff.now[29:20]) * SW'(srl_pkg::CHUNK_W2)
                  + SW'(s1_evt_ff.now[39:30]) * SW'(srl_pkg::CHUNK_W3)
                  + SW'(s1_evt_ff.now[47:40]) * SW'(srl_pkg::CHUNK_W4);

   // Fold the sum twice, then one conditional subtract gives the remainder
   assign red1   = 16'(s2_wsum_ff[SW-1:10]) * 16'(srl_pkg::CHUNK_W1) + 16'(s2_wsum_ff[9:0]);
   assign red2   = 11'(red1[15:10]) * 11'(srl_pkg::CHUNK_W1) + 11'(red1[9:0]);
   assign rem_in = (red2 >= 11'(srl_pkg::MS_PER_SECOND))
                 ? RW'(red2 - 11'(srl_pkg::MS_PER_SECOND)) : red2[RW-1:0];

   // Admission decision, pending count and report check
   always_comb begin
      now_x     = {1'b0, s3_evt_ff.now};
      boundary  = now_x - (TW+1)'(s3_rem_ff) + (TW+1)'(srl_pkg::MS_PER_SECOND);
      win_end   = {1'b0, win_start_ff} + (TW+1)'(win_ms_ff);
      in_win    = now_x < win_end;
      sec_base  = (now_x >= sec_next_ff) ? '0 : sec_cnt_ff;

      win_start_in     = win_start_ff;
      sec_next_in      = sec_next_ff;
      win_cnt_in       = win_cnt_ff;
      sec_cnt_in       = sec_cnt_ff;
      rsp_collected_in = 1'b0;

      if (s3_evt_ff.has_id) begin
         if (in_win && win_cnt_ff < spw_ff && sec_cnt_ff < sps_ff) begin
            win_cnt_in       = win_cnt_ff + CW'(1);
            sec_cnt_in       = sec_cnt_ff + CW'(1);
            rsp_collected_in = 1'b1;
         end else if (!in_win && sps_ff != '0) begin
            // open a new window at the event time
            win_start_in = s3_evt_ff.now;
            sec_next_in  = boundary;
            if (sec_base < sps_ff) begin
               sec_cnt_in       = sec_base + CW'(1);
               win_cnt_in       = CW'(1);
               rsp_collected_in = 1'b1;
            end else begin
               sec_cnt_in = sec_base;
               win_cnt_in = '0;
            end
         end
      end

      pend_base = s3_evt_ff.taken ? '0 : pend_ff;
      pend_in   = (rsp_collected_in && pend_base != srl_pkg::CNT_MAX)
                ? pend_base + CW'(1) : pend_base;

      rep_base   = (last_rep_ff == '0) ? s3_evt_ff.now : last_rep_ff;
      rep_limit  = {1'b0, rep_base} + (TW+1)'(interval_ff);
      rsp_due_in = (now_x > rep_limit) || (pend_in >= thresh_ff);
      last_rep_in = rsp_due_in ? s3_evt_ff.now : rep_base;
   end

   // Control state, limiter state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_v_ff     <= 1'b0;
         win_start_ff <= '0;
         sec_next_ff  <= (TW+1)'(srl_pkg::MS_PER_SECOND);
         win_cnt_ff   <= '0;
         sec_cnt_ff   <= '0;
         last_rep_ff  <= '0;
         pend_ff      <= '0;
         sps_ff       <= srl_pkg::SPANS_PER_SECOND_RST;
         win_ms_ff    <= srl_pkg::WINDOW_MS_RST;
         spw_ff       <= srl_pkg::SPANS_PER_WINDOW_RST;
         thresh_ff    <= srl_pkg::REPORT_THRESHOLD_RST;
         interval_ff  <= srl_pkg::REPORT_INTERVAL_MS_RST;
      end else begin
         if (ready_s1) begin
            s1_v_ff <= req_bus.valid;
         end
         if (ready_s2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (ready_s3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (ready_rsp) begin
            rsp_v_ff <= s3_v_ff;
         end
         if (s3_fire) begin
            win_start_ff <= win_start_in;
            sec_next_ff  <= sec_next_in;
            win_cnt_ff   <= win_cnt_in;
            sec_cnt_ff   <= sec_cnt_in;
            last_rep_ff  <= last_rep_in;
            pend_ff      <= pend_in;
         end
         if (csr_bus.valid) begin
            case (csr_bus.index)
               srl_pkg::CSR_SPANS_PER_SECOND:   sps_ff      <= csr_bus.data;
               srl_pkg::CSR_WINDOW_MS:          win_ms_ff   <= csr_bus.data;
               srl_pkg::CSR_SPANS_PER_WINDOW:   spw_ff      <= csr_bus.data;
               srl_pkg::CSR_REPORT_THRESHOLD:   thresh_ff   <= csr_bus.data;
               srl_pkg::CSR_REPORT_INTERVAL_MS: interval_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // Payload stages, no reset
   always_ff @(posedge clock) begin
      if (ready_s1) begin
         s1_evt_ff.now    <= req_bus.timestamp_ms;
         s1_evt_ff.has_id <= req_bus.has_trace_id;
         s1_evt_ff.taken  <= req_bus.report_taken;
      end
      if (ready_s2) begin
         s2_evt_ff  <= s1_evt_ff;
         s2_wsum_ff <= wsum_in;
      end
      if (ready_s3) begin
         s3_evt_ff <= s2_evt_ff;
         s3_rem_ff <= rem_in;
      end
      if (s3_fire) begin
         rsp_collected_ff <= rsp_collected_in;
         rsp_due_ff       <= rsp_due_in;
      end
   end

   // Checks
   `SRL_ASSERT_NEXT(a_no_id_no_collect, clock, reset, s3_fire && !s3_evt_ff.has_id, !rsp_collected_ff)
   `SRL_ASSERT_NEXT(a_taken_pending_low, clock, reset, s3_fire && s3_evt_ff.taken, pend_ff <= CW'(1))
   `SRL_ASSERT_NEXT(a_collect_counts, clock, reset, s3_fire && rsp_collected_in, win_cnt_ff != '0 && sec_cnt_ff != '0)
   `SRL_ASSERT_NEXT(a_stage_hold, clock, reset, s3_v_ff && !ready_rsp, s3_v_ff && $stable(s3_rem_ff))
   `SRL_ASSERT_SAME(a_collect_budget, clock, reset, s3_fire && rsp_collected_in, sps_ff != '0)

endmodule

// ===== verif/testbench.sv =====
module testbench;

   localparam int TS_W       = srl_pkg::TS_W;
   localparam int CNT_W      = srl_pkg::CNT_W;
   localparam int CSR_IDX_W  = srl_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = srl_pkg::CSR_DATA_W;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   localparam int LATENCY      = 3;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int FILL_EVENTS  = 40;

   // Indexes past the last register
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_FIRST = srl_pkg::CSR_REPORT_INTERVAL_MS + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LAST     = '1;

   localparam logic [TS_W-1:0]       TS_MAX  = '1;
   localparam logic [CSR_DATA_W-1:0] CSR_MAX = '1;

   typedef enum int {STRESS_NONE, STRESS_HOLDOFF, STRESS_DRAIN} stress_type;

   typedef struct packed {
      logic             collected;
      logic             report_due;
      logic [CNT_W-1:0] pending_count;
   } decision_type;

   // Admission and report predictor with the queue of decisions still owed
   class admission_scoreboard;
      logic [CSR_DATA_W-1:0] per_second_limit;
      logic [CSR_DATA_W-1:0] window_len_ms;
      logic [CSR_DATA_W-1:0] per_window_limit;
      logic [CSR_DATA_W-1:0] count_trigger;
      logic [CSR_DATA_W-1:0] report_period;
      logic [TS_W-1:0]       window_start;
      logic [TS_W-1:0]       last_report;
      logic [CNT_W-1:0]      window_admits;
      logic [CNT_W-1:0]      second_admits;
      logic [CNT_W-1:0]      pending;
      decision_type          expected_decisions[$];
      int                    errors;

      function new();
         per_second_limit = srl_pkg::SPANS_PER_SECOND_RST;
         window_len_ms    = srl_pkg::WINDOW_MS_RST;
         per_window_limit = srl_pkg::SPANS_PER_WINDOW_RST;
         count_trigger    = srl_pkg::REPORT_THRESHOLD_RST;
         report_period    = srl_pkg::REPORT_INTERVAL_MS_RST;
         window_start     = '0;
         last_report      = '0;
         window_admits    = '0;
         second_admits    = '0;
         pending          = '0;
         errors           = 0;
      endfunction

      // Mirror a register write; unknown indexes change nothing
      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            srl_pkg::CSR_SPANS_PER_SECOND:   per_second_limit = data;
            srl_pkg::CSR_WINDOW_MS:          window_len_ms    = data;
            srl_pkg::CSR_SPANS_PER_WINDOW:   per_window_limit = data;
            srl_pkg::CSR_REPORT_THRESHOLD:   count_trigger    = data;
            srl_pkg::CSR_REPORT_INTERVAL_MS: report_period    = data;
            default: ;
         endcase
      endfunction

      function void note_event(srl_pkg::srl_evt_type evt);
         logic [63:0]  now;
         logic [63:0]  window_end;
         logic         admitted;
         logic         due;
         decision_type decision;
         now        = 64'(evt.now);
         window_end = 64'(window_start) + 64'(window_len_ms);
         admitted   = 1'b0;
         due        = 1'b0;
         // Clear the pending count when a report went out before this event
         if (evt.taken) pending = '0;
         // Admit inside the open window, or open a new one once it has expired
         if (evt.has_id) begin
            if (now < window_end && window_admits < per_window_limit &&
                second_admits < per_second_limit) begin
               window_admits = window_admits + CNT_W'(1);
               second_admits = second_admits + CNT_W'(1);
               admitted      = 1'b1;
            end else if (now >= window_end && per_second_limit != '0) begin
               window_admits = '0;
               if (now / 64'(srl_pkg::MS_PER_SECOND) >
                   64'(window_start) / 64'(srl_pkg::MS_PER_SECOND))
                  second_admits = '0;
               window_start = evt.now;
               if (second_admits < per_second_limit) begin
                  second_admits = second_admits + CNT_W'(1);
                  window_admits = CNT_W'(1);
                  admitted      = 1'b1;
               end
            end
         end
         if (admitted && pending != srl_pkg::CNT_MAX) pending = pending + CNT_W'(1);
         // Report check: a zero report time first takes the event time
         if (last_report == '0) last_report = evt.now;
         if (now > 64'(last_report) + 64'(report_period) || pending >= count_trigger) begin
            last_report = evt.now;
            due         = 1'b1;
         end
         decision.collected     = admitted;
         decision.report_due    = due;
         decision.pending_count = pending;
         expected_decisions.push_back(decision);
      endfunction

      function void check_result(logic collected, logic due, logic [CNT_W-1:0] count);
         decision_type want;
         if (expected_decisions.size() == 0) begin
            $error("result transaction with no event outstanding");
            errors++;
            return;
         end
         want = expected_decisions.pop_front();
         if (collected !== want.collected) begin
            $error("collected: expected %0d, actual %0d", want.collected, collected);
            errors++;
         end
         if (due !== want.report_due) begin
            $error("report_due: expected %0d, actual %0d", want.report_due, due);
            errors++;
         end
         if (count !== want.pending_count) begin
            $error("pending_count: expected %0d, actual %0d", want.pending_count, count);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_decisions.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   srl_req_if req_bus ();
   srl_rsp_if rsp_bus ();
   srl_csr_if csr_bus ();

   span_rate_limiter_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   admission_scoreboard board;
   logic [TS_W-1:0]     now_ms;
   bit                  idle_on;
   bit                  hold_request;
   int unsigned         cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check every result transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_result(rsp_bus.collected, rsp_bus.report_due, rsp_bus.pending_count);
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: honor a requested hold-off, else stall at random
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_event(input logic [TS_W-1:0] stamp, input logic has_id,
                             input logic taken);
      srl_pkg::srl_evt_type evt;
      int                   gap;
      evt.now    = stamp;
      evt.has_id = has_id;
      evt.taken  = taken;
      gap        = 0;
      if (idle_on && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.timestamp_ms <= evt.now;
      req_bus.has_trace_id <= evt.has_id;
      req_bus.report_taken <= evt.taken;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_event(evt);
   endtask

   // Stop offering events and wait for every owed result
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      board.write_register(index, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] per_second,
                            input logic [CSR_DATA_W-1:0] window_len,
                            input logic [CSR_DATA_W-1:0] per_window,
                            input logic [CSR_DATA_W-1:0] threshold,
                            input logic [CSR_DATA_W-1:0] interval);
      wait_for_results();
      write_csr(srl_pkg::CSR_SPANS_PER_SECOND, per_second);
      write_csr(srl_pkg::CSR_WINDOW_MS, window_len);
      write_csr(srl_pkg::CSR_SPANS_PER_WINDOW, per_window);
      write_csr(srl_pkg::CSR_REPORT_THRESHOLD, threshold);
      write_csr(srl_pkg::CSR_REPORT_INTERVAL_MS, interval);
      // Writes past the register file must not disturb anything
      for (int idx = int'(CSR_UNUSED_FIRST); idx <= int'(CSR_IDX_LAST); idx++)
         write_csr(CSR_IDX_W'(idx), CSR_DATA_W'($urandom()));
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly forward time in small steps so windows and budgets get exercised
   task automatic run_random(input int count, input stress_type stress);
      int r;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (i == count / 2) begin
            if (stress == STRESS_HOLDOFF) begin
               idle_on      = 1'b0;
               hold_request = 1'b1;
            end else if (stress == STRESS_DRAIN) begin
               wait_for_results();
            end
         end
         r = $urandom_range(0, 99);
         if (r < 45)
            now_ms = now_ms + TS_W'($urandom_range(0, 3));
         else if (r < 75)
            now_ms = now_ms + TS_W'($urandom_range(1, 40));
         else if (r < 90)
            now_ms = now_ms + TS_W'($urandom_range(40, 1500));
         else if (r < 96) begin
            if (now_ms > TS_W'(300)) now_ms = now_ms - TS_W'($urandom_range(1, 300));
         end else
            now_ms = now_ms + TS_W'($urandom_range(1000, 200000));
         send_event(now_ms, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      board        = new();
      reset        = 1'b1;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      now_ms       = '0;
      req_bus.valid        = 1'b0;
      req_bus.timestamp_ms = '0;
      req_bus.has_trace_id = 1'b0;
      req_bus.report_taken = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Default settings: time zero, missing ids, window edges, time going back
      send_event(TS_W'(0), 1'b1, 1'b0);
      send_event(TS_W'(0), 1'b0, 1'b0);
      send_event(TS_W'(40), 1'b1, 1'b1);
      send_event(TS_W'(99), 1'b1, 1'b0);
      send_event(TS_W'(100), 1'b1, 1'b0);
      send_event(TS_W'(60), 1'b1, 1'b0);
      send_event(TS_W'(999), 1'b1, 1'b0);
      send_event(TS_W'(1000), 1'b1, 1'b0);
      send_event(TS_W'(1500), 1'b0, 1'b0);
      send_event(TS_W'(2100), 1'b1, 1'b0);
      send_event(TS_W'(2101), 1'b1, 1'b1);

      // Tight budgets: window full, second full, new second
      configure(CSR_DATA_W'(3), CSR_DATA_W'(10), CSR_DATA_W'(2), CSR_DATA_W'(2),
                CSR_DATA_W'(5));
      send_event(TS_W'(3000), 1'b1, 1'b0);
      send_event(TS_W'(3001), 1'b1, 1'b0);
      send_event(TS_W'(3002), 1'b1, 1'b0);
      send_event(TS_W'(3010), 1'b1, 1'b0);
      send_event(TS_W'(3011), 1'b1, 1'b0);
      send_event(TS_W'(3020), 1'b1, 1'b0);
      send_event(TS_W'(4000), 1'b1, 1'b1);
      now_ms = TS_W'(5000);

      // Random traffic over several settings, extremes among them
      configure(srl_pkg::SPANS_PER_SECOND_RST, srl_pkg::WINDOW_MS_RST,
                srl_pkg::SPANS_PER_WINDOW_RST, srl_pkg::REPORT_THRESHOLD_RST,
                srl_pkg::REPORT_INTERVAL_MS_RST);
      run_random(250, STRESS_HOLDOFF);
      configure(CSR_DATA_W'(7), CSR_DATA_W'(20), CSR_DATA_W'(3), CSR_DATA_W'(5),
                CSR_DATA_W'(40));
      run_random(250, STRESS_DRAIN);
      configure(CSR_DATA_W'(0), CSR_DATA_W'(1), CSR_DATA_W'(0), CSR_DATA_W'(0),
                CSR_DATA_W'(0));
      run_random(150, STRESS_NONE);
      configure(CSR_MAX, CSR_MAX, CSR_MAX, CSR_MAX, CSR_MAX);
      run_random(250, STRESS_DRAIN);
      configure(CSR_DATA_W'(1), CSR_DATA_W'(1), CSR_MAX, CSR_MAX, CSR_DATA_W'(0));
      run_random(200, STRESS_NONE);
      for (int k = 0; k < 3; k++) begin
         configure(CSR_DATA_W'($urandom_range(1, 50)), CSR_DATA_W'($urandom_range(1, 300)),
                   CSR_DATA_W'($urandom_range(0, 20)), CSR_DATA_W'($urandom_range(0, 30)),
                   CSR_DATA_W'($urandom_range(0, 2000)));
         run_random(200, (k == 1) ? STRESS_HOLDOFF : STRESS_NONE);
      end
      configure(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom_range(1, 65535)),
                CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()));
      run_random(150, STRESS_NONE);

      // Back-to-back admissions under wide budgets
      configure(CSR_MAX, CSR_MAX, CSR_MAX, CSR_MAX, CSR_MAX);
      idle_on = 1'b0;
      now_ms  = now_ms + TS_W'(200000);
      for (int i = 0; i < FILL_EVENTS; i++)
         send_event(now_ms + TS_W'(i), 1'b1, i == 0);

      // Full-width timestamps last, since a window opened near the top never expires
      configure(srl_pkg::SPANS_PER_SECOND_RST, srl_pkg::WINDOW_MS_RST,
                srl_pkg::SPANS_PER_WINDOW_RST, srl_pkg::REPORT_THRESHOLD_RST,
                srl_pkg::REPORT_INTERVAL_MS_RST);
      idle_on = 1'b1;
      for (int i = 0; i < 30; i++)
         send_event(TS_W'({$urandom(), $urandom()}), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) == 0);
      send_event(TS_MAX, 1'b1, 1'b0);
      send_event(TS_MAX, 1'b1, 1'b1);
      send_event(TS_MAX, 1'b0, 1'b0);

      wait_for_results();
      if (board.errors == 0 && board.outstanding() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/srl_pkg.sv
design/srl_if.sv
design/span_rate_limiter_core.sv
verif/testbench.sv
